/* rtl/isa_pkg.sv */
package isa_pkg;

  localparam int unsigned MAX_STATIONS = 256;
  localparam int unsigned SEG_W        = 8;   // segment index width
  localparam int unsigned STN_W        = 9;   // station count width
  localparam int unsigned CNT_W        = 16;  // booked count width

  localparam logic [0:0] REG_SEAT_CAPACITY = 1'b0;
  localparam logic [0:0] REG_STATION_COUNT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load_item;     // capture a request
    logic clear_step;    // zero one entry of the count store
    logic check_step;    // read one covered segment for the capacity check
    logic start_update;  // rewind the segment pointer to the range start
    logic update_step;   // read one covered segment for the increment
    logic out_load;      // load the result register
  } isa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;    // last entry of the clearing pass
    logic empty;         // clipped range covers no segment
    logic ptr_last;      // pointer is on the last covered segment
    logic fail;          // some covered segment is full
    logic out_busy;      // result register holds a result not yet taken
  } isa_status_t;

endpackage

/* rtl/isa_ram.sv */
module isa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/isa_datapath.sv */
module isa_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_addr,
  input  logic [isa_pkg::CNT_W-1:0]           cfg_data,
  input  logic [isa_pkg::SEG_W-1:0]           from_station,
  input  logic [isa_pkg::SEG_W-1:0]           to_station,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                accepted,
  input  isa_pkg::isa_cmd_t                   cmd,
  output isa_pkg::isa_status_t                status
);

  logic [isa_pkg::CNT_W-1:0] seat_capacity;
  logic [isa_pkg::STN_W-1:0] station_count;
  logic [isa_pkg::STN_W-1:0] segs;
  logic [isa_pkg::STN_W-1:0] hi_clip;
  logic [isa_pkg::SEG_W-1:0] lo;
  logic [isa_pkg::STN_W-1:0] hi;
  logic [isa_pkg::SEG_W-1:0] ptr;
  logic [isa_pkg::SEG_W-1:0] wptr;
  logic [isa_pkg::SEG_W-1:0] clr_ptr;
  logic                      chk_pend;
  logic                      upd_pend;
  logic                      fail;
  logic                      ram_we;
  logic [isa_pkg::SEG_W-1:0] ram_waddr;
  logic [isa_pkg::CNT_W-1:0] ram_wdata;
  logic [isa_pkg::CNT_W-1:0] ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seat_capacity <= isa_pkg::CNT_W'(1);
      station_count <= isa_pkg::STN_W'(isa_pkg::MAX_STATIONS);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        isa_pkg::REG_SEAT_CAPACITY: seat_capacity <= cfg_data;
        isa_pkg::REG_STATION_COUNT: station_count <= cfg_data[isa_pkg::STN_W-1:0];
        default: ;
      endcase
    end
  end

  // clip the range to the segments in use
  always_comb begin
    if (station_count > isa_pkg::STN_W'(isa_pkg::MAX_STATIONS)) begin
      segs = isa_pkg::STN_W'(isa_pkg::MAX_STATIONS - 1);
    end else if (station_count != '0) begin
      segs = station_count - isa_pkg::STN_W'(1);
    end else begin
      segs = '0;
    end
    hi_clip = ({1'b0, to_station} > segs) ? segs : {1'b0, to_station};
  end

  // request registers and sweep pointer
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      lo  <= from_station;
      hi  <= hi_clip;
      ptr <= from_station;
    end else if (cmd.start_update) begin
      ptr <= lo;
    end else if (cmd.check_step || cmd.update_step) begin
      ptr <= ptr + isa_pkg::SEG_W'(1);
    end
    wptr <= ptr;
  end

  // read tracking, clear pointer, fail flag
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_pend <= 1'b0;
      upd_pend <= 1'b0;
      clr_ptr  <= '0;
      fail     <= 1'b0;
    end else begin
      chk_pend <= cmd.check_step;
      upd_pend <= cmd.update_step;
      if (cmd.clear_step) begin
        clr_ptr <= clr_ptr + isa_pkg::SEG_W'(1);
      end
      if (cmd.load_item) begin
        fail <= 1'b0;
      end else if (chk_pend && (ram_rdata >= seat_capacity)) begin
        fail <= 1'b1;
      end
    end
  end

  // count store write port: clearing pass or increment write-back
  always_comb begin
    ram_we    = cmd.clear_step || upd_pend;
    ram_waddr = cmd.clear_step ? clr_ptr : wptr;
    ram_wdata = cmd.clear_step ? '0 : ram_rdata + isa_pkg::CNT_W'(1);
  end

  isa_ram #(
    .Width(isa_pkg::CNT_W),
    .Depth(isa_pkg::MAX_STATIONS)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ptr),
    .rdata(ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted <= ~fail;
    end
  end

  always_comb begin
    status.clear_last = (clr_ptr == isa_pkg::SEG_W'(isa_pkg::MAX_STATIONS - 1));
    status.empty      = ({1'b0, lo} >= hi);
    status.ptr_last   = (({1'b0, ptr} + isa_pkg::STN_W'(1)) == hi);
    status.fail       = fail;
    status.out_busy   = out_valid && !out_ready;
  end

endmodule

/* rtl/isa_ctrl.sv */
module isa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  isa_pkg::isa_status_t status,
  output isa_pkg::isa_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_EVAL     = 8'b0000_0100,
    S_CHECK    = 8'b0000_1000,
    S_CHK_WAIT = 8'b0001_0000,
    S_DECIDE   = 8'b0010_0000,
    S_UPDATE   = 8'b0100_0000,
    S_RESPOND  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = status.empty ? S_RESPOND : S_CHECK;
      end
      S_CHECK: begin
        cmd.check_step = 1'b1;
        if (status.ptr_last) state_next = S_CHK_WAIT;
      end
      S_CHK_WAIT: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (status.fail) begin
          state_next = S_RESPOND;
        end else begin
          cmd.start_update = 1'b1;
          state_next       = S_UPDATE;
        end
      end
      S_UPDATE: begin
        // the last write-back lands during the first respond cycle
        cmd.update_step = 1'b1;
        if (status.ptr_last) state_next = S_RESPOND;
      end
      S_RESPOND: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/interval_seat_admission.sv */
// Seat admission over a line of stations. Each request (from_station,
// to_station) covers segments from_station..to_station-1, clipped to the
// segments in use; it is accepted and books one seat on each covered segment
// only if every one of them has a booked count below seat_capacity. Booked
// counts live in a 256 x 16 single-port-read RAM swept one segment a cycle;
// a refused request skips the increment sweep, and an empty range skips both
// sweeps. After reset a clearing pass over all 256 entries zeroes the counts;
// no request is taken during it, configuration writes are. The next request is
// taken while a result waits in the output register.
module interval_seat_admission (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] from_station, [15:8] to_station
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] accepted, [7:1] zero
);

  isa_pkg::isa_cmd_t    cmd;
  isa_pkg::isa_status_t status;
  logic                 accepted;

  isa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  isa_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .from_station(s_axis_tdata[7:0]),
    .to_station  (s_axis_tdata[15:8]),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .accepted    (accepted),
    .cmd         (cmd),
    .status      (status)
  );

  assign m_axis_tdata = {7'b0, accepted};

  // a refused request never reaches the increment sweep
  a_no_book_on_fail: assert property (@(posedge clk) disable iff (rst)
    cmd.update_step |-> !status.fail)
    else $error("increment sweep on a refused request");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result register overwritten");

  // clear, check and update sweeps never overlap
  a_one_sweep: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.check_step, cmd.update_step}))
    else $error("overlapping sweeps");

endmodule
